>>> src/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_MODIFY = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_UP    = 5'b00010,
    S_DOWN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam logic [WORD_W-1:0] NO_WORD = '1;

endpackage
`default_nettype wire

>>> src/positional_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// a refused insert goes straight to the result; modify writes the word in place; read
// fetches the word; remove fetches it, then moves each later entry down; insert moves each
// later entry up, top first, then writes the word; one memory move per cycle
// a new item is taken only once the last one is through; the result sits in an
// output register so the next item is taken while it waits
// reset (rst, synchronous): list empty, no result pending; stored words are not cleared
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // cmd[1:0], position[8:2], word_in[40:9], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0] m_tdata        // word_out[31:0], word_valid[32], entry_count[39:33],
                                     // refused[40], zero pad
);
  import ple_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W - 1) ? CW : POS_W - 1;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  state_t            state;
  cmd_t              op;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_ptr;
  logic [CW-1:0]     lim;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     wr_addr;
  logic              pend;
  logic              pend_cap;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] res_word;
  logic              res_valid;
  logic              res_refused;

  logic [WORD_W-1:0]  m_word;
  logic               m_valid_bit;
  logic [COUNT_W-1:0] m_count;
  logic               m_refused;

  cmd_t              in_cmd;
  logic [POS_W-1:0]  in_pos;
  logic [WORD_W-1:0] in_word;
  logic              pos_ok;
  logic [AW-1:0]     pos_idx;
  logic [AW-1:0]     tail_idx;
  logic [AW-1:0]     clamp_idx;

  assign in_cmd  = cmd_t'(s_tdata[1:0]);
  assign in_pos  = s_tdata[8:2];
  assign in_word = s_tdata[40:9];

  assign pos_ok    = !in_pos[POS_W-1] && (CMPW'(in_pos[POS_W-2:0]) < CMPW'(count));
  assign pos_idx   = AW'(in_pos[POS_W-2:0]);
  assign tail_idx  = AW'(count - CW'(1));
  assign clamp_idx = in_pos[POS_W-1] ? '0 : (pos_ok ? pos_idx : tail_idx);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {7'd0, m_refused, m_count, m_valid_bit, m_word};

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = mem_rdata;
    mem_raddr = AW'(rd_ptr);
    case (state)
      S_UP: begin
        mem_we    = pend;
        mem_raddr = AW'(rd_ptr - CW'(1));
      end
      S_DOWN: begin
        mem_we = pend && !pend_cap;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = word;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op          <= in_cmd;
            word        <= in_word;
            res_word    <= NO_WORD;
            res_valid   <= 1'b0;
            res_refused <= 1'b0;
            pend        <= 1'b0;
            pend_cap    <= 1'b0;
            case (in_cmd)
              CMD_INSERT: begin
                if (count == CW'(CAPACITY)) begin
                  res_refused <= 1'b1;
                  state       <= S_DONE;
                end else begin
                  idx    <= pos_ok ? pos_idx : AW'(count);
                  rd_ptr <= count;
                  state  <= S_UP;
                end
              end
              CMD_REMOVE: begin
                if (count == '0) begin
                  state <= S_DONE;
                end else begin
                  idx    <= pos_ok ? pos_idx : tail_idx;
                  rd_ptr <= pos_ok ? CW'(pos_idx) : CW'(tail_idx);
                  lim    <= count;
                  state  <= S_DOWN;
                end
              end
              CMD_READ: begin
                if (count == '0) begin
                  state <= S_DONE;
                end else begin
                  idx    <= clamp_idx;
                  rd_ptr <= CW'(clamp_idx);
                  lim    <= CW'(clamp_idx) + CW'(1);
                  state  <= S_DOWN;
                end
              end
              CMD_MODIFY: begin
                if (count == '0) begin
                  state <= S_DONE;
                end else begin
                  idx   <= clamp_idx;
                  state <= S_WRITE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        // shift entries up, one move per cycle, top first
        S_UP: begin
          if (rd_ptr > CW'(idx)) begin
            pend    <= 1'b1;
            wr_addr <= AW'(rd_ptr);
            rd_ptr  <= rd_ptr - CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_WRITE;
            end
          end
        end
        // fetch the word at idx, then close the gap for remove
        S_DOWN: begin
          if (pend && pend_cap) begin
            res_word  <= mem_rdata;
            res_valid <= 1'b1;
          end
          if (rd_ptr < lim) begin
            pend     <= 1'b1;
            pend_cap <= (rd_ptr == CW'(idx));
            wr_addr  <= AW'(rd_ptr - CW'(1));
            rd_ptr   <= rd_ptr + CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (op == CMD_REMOVE) begin
                count <= count - CW'(1);
              end
              state <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          if (op == CMD_INSERT) begin
            count <= count + CW'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            m_word      <= res_word;
            m_valid_bit <= res_valid;
            m_count     <= COUNT_W'(count);
            m_refused   <= res_refused;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ple_pkg::*;

  localparam int CAPACITY = 64;

  typedef struct {
    logic [WORD_W-1:0]  word;
    logic               valid;
    logic [COUNT_W-1:0] count;
    logic               refused;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // cmd[1:0], position[8:2], word_in[40:9], zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // word_out[31:0], word_valid[32], entry_count[39:33], refused[40]

  logic [WORD_W-1:0] list_words [0:CAPACITY-1];
  int                list_len;
  list_result_t      pending_results [$];
  int                mismatch_count;
  int                tx_gap_max = 4;
  int                rx_gap_max = 4;
  int                rx_hold = 0;
  bit                rst_done = 1'b0;

  always #4 clk = ~clk;

  positional_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic int clamp_index(int p);
    if (p < 0) return 0;
    if (p >= list_len) return list_len - 1;
    return p;
  endfunction

  // applies one operation to the shadow list and returns what the block should report
  function automatic list_result_t list_apply(cmd_t c, logic signed [POS_W-1:0] pos,
                                              logic [WORD_W-1:0] w);
    list_result_t r;
    int p;
    int idx;
    r.word    = NO_WORD;
    r.valid   = 1'b0;
    r.refused = 1'b0;
    p = pos;
    case (c)
      CMD_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.refused = 1'b1;
        end else begin
          idx = (p < 0 || p >= list_len) ? list_len : p;
          for (int i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
          list_words[idx] = w;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (list_len > 0) begin
          idx = (p < 0 || p >= list_len) ? list_len - 1 : p;
          r.word  = list_words[idx];
          r.valid = 1'b1;
          for (int i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      CMD_READ: begin
        if (list_len > 0) begin
          r.word  = list_words[clamp_index(p)];
          r.valid = 1'b1;
        end
      end
      default: begin
        if (list_len > 0) list_words[clamp_index(p)] = w;
      end
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_item(input cmd_t c, input int pos, input logic [WORD_W-1:0] w);
    int gap;
    logic [POS_W-1:0] p7;
    gap = $urandom_range(0, tx_gap_max);
    p7  = pos[POS_W-1:0];
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, w, p7, c};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    pending_results.push_back(list_apply(c, p7, w));
  endtask

  function automatic int pick_pos();
    case ($urandom_range(0, 9))
      0: return -1;
      1: return int'($urandom_range(0, 127)) - 64;
      2: return list_len;
      default: return (list_len > 0) ? int'($urandom_range(0, list_len - 1)) : 0;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // wanders between filling and draining so both full and empty lists come up often
  task automatic random_ops(input int n);
    bit filling;
    int r;
    cmd_t c;
    filling = (list_len < CAPACITY / 2);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < (filling ? 50 : 15)) c = CMD_INSERT;
      else if (r < 65) c = CMD_REMOVE;
      else if (r < 85) c = CMD_READ;
      else c = CMD_MODIFY;
      send_item(c, pick_pos(), pick_word());
      if (filling && list_len == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (!filling && list_len == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      if ($urandom_range(0, 99) == 0) filling = !filling;
    end
  endtask

  task automatic test_directed();
    // empty list
    send_item(CMD_READ, 0, '0);
    send_item(CMD_REMOVE, -1, '0);
    send_item(CMD_MODIFY, 5, 32'h1234_5678);
    // tail, head, beyond count, middle, at count
    send_item(CMD_INSERT, -1, 32'h8000_0000);
    send_item(CMD_INSERT, 0, 32'h7fff_ffff);
    send_item(CMD_INSERT, 63, 32'h0000_0000);
    send_item(CMD_INSERT, 1, 32'hffff_ffff);
    send_item(CMD_INSERT, 4, 32'h5555_aaaa);
    // clamped reads and modifies
    send_item(CMD_READ, -64, '0);
    send_item(CMD_READ, 63, '0);
    send_item(CMD_READ, 2, '0);
    send_item(CMD_READ, -1, '0);
    send_item(CMD_MODIFY, -64, 32'haaaa_5555);
    send_item(CMD_MODIFY, 63, 32'h0000_0001);
    send_item(CMD_MODIFY, 2, 32'h8000_0001);
    send_item(CMD_READ, 0, '0);
    send_item(CMD_READ, 4, '0);
    send_item(CMD_READ, 2, '0);
    // removes at head, tail, beyond count, middle, until empty
    send_item(CMD_REMOVE, 0, '0);
    send_item(CMD_REMOVE, -1, '0);
    send_item(CMD_REMOVE, 63, '0);
    send_item(CMD_REMOVE, 1, '0);
    send_item(CMD_REMOVE, 0, '0);
    send_item(CMD_READ, 3, '0);
  endtask

  task automatic test_fill_to_full();
    while (list_len < CAPACITY) send_item(CMD_INSERT, pick_pos(), pick_word());
    send_item(CMD_INSERT, -1, 32'hdead_beef);
    send_item(CMD_INSERT, 0, 32'hdead_beef);
    send_item(CMD_INSERT, 63, 32'hdead_beef);
    send_item(CMD_READ, 63, '0);
    send_item(CMD_READ, -64, '0);
    send_item(CMD_MODIFY, 63, pick_word());
    send_item(CMD_MODIFY, 0, pick_word());
    send_item(CMD_REMOVE, 0, '0);
    send_item(CMD_INSERT, 0, pick_word());
    send_item(CMD_INSERT, 10, pick_word());
    send_item(CMD_REMOVE, 63, '0);
  endtask

  task automatic test_backpressure();
    rx_hold    = 200;
    tx_gap_max = 0;
    random_ops(16);
    tx_gap_max = 4;
  endtask

  task automatic test_no_idle();
    tx_gap_max = 0;
    rx_gap_max = 0;
    random_ops(60);
    tx_gap_max = 4;
    rx_gap_max = 4;
  endtask

  task automatic test_drain();
    while (list_len > 0) send_item(CMD_REMOVE, pick_pos(), pick_word());
    send_item(CMD_REMOVE, 0, '0);
    send_item(CMD_MODIFY, -1, pick_word());
    send_item(CMD_READ, 63, '0);
  endtask

  // receiver side
  initial begin
    int gap;
    wait (rst_done);
    forever begin
      gap = (rx_hold > 0) ? rx_hold : $urandom_range(0, rx_gap_max);
      rx_hold = 0;
      if (gap > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t e;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: m_tdata=%h", m_tdata);
        mismatch_count++;
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[31:0] !== e.word) begin
          $error("word_out: expected %h, got %h", e.word, m_tdata[31:0]);
          mismatch_count++;
        end
        if (m_tdata[32] !== e.valid) begin
          $error("word_valid: expected %b, got %b", e.valid, m_tdata[32]);
          mismatch_count++;
        end
        if (m_tdata[39:33] !== e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, m_tdata[39:33]);
          mismatch_count++;
        end
        if (m_tdata[40] !== e.refused) begin
          $error("refused: expected %b, got %b", e.refused, m_tdata[40]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    list_len       = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    rst_done = 1'b1;

    test_directed();
    test_fill_to_full();
    test_backpressure();
    random_ops(480);
    test_no_idle();
    test_drain();

    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
src/ple_pkg.sv
src/positional_list_engine_unit.sv
tb/sv/tb.sv
